@@ src/sofst_pkg.sv @@
// types, constants and codes shared by the offset table search block
`default_nettype none

package sofst_pkg;

  localparam int unsigned CMD_W           = 2;
  localparam int unsigned INDEX_W         = 10;
  localparam int unsigned OFFSET_W        = 64;
  localparam int unsigned BLOCK_W         = 10;
  localparam int unsigned STATUS_W        = 2;
  localparam int unsigned DEF_MAX_ENTRIES = 1024;
  // range width at which the binary search hands over to the upward scan
  localparam int unsigned LINEAR_SPAN     = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_MODIFY = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_MISS  = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SEARCH,
    S_SCAN,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic load;
    logic exec;
    logic search;
    logic scan;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_lookup;
    logic empty;
    logic wide;
    logic scan_end;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

@@ src/sofst_req_if.sv @@
// request channel: command, entry index and offset
`default_nettype none

interface sofst_req_if
  import sofst_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [INDEX_W-1:0]  entry_index;
  logic [OFFSET_W-1:0] offset_value;

  modport source (output valid, output cmd, output entry_index, output offset_value,
                  input ready);
  modport sink   (input valid, input cmd, input entry_index, input offset_value,
                  output ready);
endinterface

`default_nettype wire

@@ src/sofst_rsp_if.sv @@
// response channel: block number and status
`default_nettype none

interface sofst_rsp_if
  import sofst_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [BLOCK_W-1:0]  block_number;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output block_number, output status, input ready);
  modport sink   (input valid, input block_number, input status, output ready);
endinterface

`default_nettype wire

@@ src/sofst_ctrl.sv @@
// sequencer for accept, execute, binary search, linear scan and response
`default_nettype none

module sofst_ctrl
  import sofst_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (status_i.is_lookup && !status_i.empty) begin
          state_d = status_i.wide ? S_SEARCH : S_SCAN;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_SEARCH: begin
        state_d = status_i.wide ? S_SEARCH : S_SCAN;
      end
      S_SCAN: begin
        if (status_i.scan_end) state_d = S_FINISH;
      end
      S_FINISH: begin
        if (status_i.out_free) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_EXEC:   cmd_o.exec   = 1'b1;
      S_SEARCH: cmd_o.search = 1'b1;
      S_SCAN:   cmd_o.scan   = 1'b1;
      S_FINISH: cmd_o.out_load = status_i.out_free;
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ src/sofst_dp.sv @@
// datapath: offset memory, entry count, search range and response register
`default_nettype none

module sofst_dp
  import sofst_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = DEF_MAX_ENTRIES
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  ctrl_cmd_t            cmd_i,
  output dp_status_t           status_o,
  input  wire  [CMD_W-1:0]     in_cmd_i,
  input  wire  [INDEX_W-1:0]   in_index_i,
  input  wire  [OFFSET_W-1:0]  in_offset_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output logic [BLOCK_W-1:0]   out_block_o,
  output logic [STATUS_W-1:0]  out_status_o
);

  localparam int unsigned AW = $clog2(MAX_ENTRIES);
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

  logic [OFFSET_W-1:0] mem [MAX_ENTRIES];

  logic [CMD_W-1:0]    op_q;
  logic [OFFSET_W-1:0] key_q;
  logic [INDEX_W-1:0]  idx_q;
  logic [CW-1:0]       count_q;
  logic [AW-1:0]       lo_q, lo_d, hi_q, hi_d, ptr_q, ptr_d;
  logic [OFFSET_W-1:0] rd_data_q;
  logic [BLOCK_W-1:0]  res_blk_q, res_blk_d;
  status_e             res_st_q, res_st_d;
  logic                out_valid_q;
  logic [BLOCK_W-1:0]  out_blk_q;
  status_e             out_st_q;

  logic          is_lookup, is_append, is_modify, empty, full, in_range;
  logic          wide, above, at_hi, scan_end, wr_en;
  logic [AW-1:0] mid, wr_addr;
  logic [AW:0]   lo_hi_sum;

  assign is_lookup = (op_q == CMD_LOOKUP);
  assign is_append = (op_q == CMD_APPEND);
  assign is_modify = (op_q == CMD_MODIFY);
  assign empty     = (count_q == '0);
  assign full      = (32'(count_q) >= 32'(MAX_ENTRIES));
  assign in_range  = (32'(idx_q) < 32'(count_q));

  // narrowed range for this cycle
  always_comb begin
    lo_d = lo_q;
    hi_d = hi_q;
    if (cmd_i.exec) begin
      lo_d = '0;
      hi_d = AW'(count_q - CW'(1));
    end else if (cmd_i.search) begin
      if (key_q <= rd_data_q) hi_d = ptr_q;
      else                    lo_d = ptr_q;
    end
  end

  assign wide      = (32'(hi_d - lo_d) > 32'(LINEAR_SPAN));
  assign lo_hi_sum = {1'b0, lo_d} + {1'b0, hi_d};
  assign mid       = lo_hi_sum[AW:1];

  // read pointer: midpoint while searching, then walks upward from lo
  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.exec || cmd_i.search) begin
      ptr_d = wide ? mid : lo_d;
    end else if (cmd_i.scan) begin
      ptr_d = ptr_q + AW'(1);
    end
  end

  assign above    = (rd_data_q > key_q);
  assign at_hi    = (ptr_q == hi_q);
  assign scan_end = above || at_hi;

  assign wr_en   = cmd_i.exec && ((is_append && !full) || (is_modify && in_range));
  assign wr_addr = is_append ? AW'(count_q) : AW'(idx_q);

  always_comb begin
    res_blk_d = '0;
    res_st_d  = ST_OK;
    if (cmd_i.scan) begin
      if (above) begin
        if (ptr_q == '0) res_st_d = ST_MISS;
        else             res_blk_d = BLOCK_W'(ptr_q - AW'(1));
      end else begin
        res_blk_d = BLOCK_W'(hi_q);
      end
    end else begin
      case (op_q)
        CMD_LOOKUP: res_st_d = ST_MISS;
        CMD_APPEND: begin
          if (full) res_st_d = ST_FULL;
          else      res_blk_d = BLOCK_W'(count_q);
        end
        CMD_MODIFY: begin
          if (in_range) res_blk_d = idx_q;
          else          res_st_d  = ST_RANGE;
        end
        default: res_st_d = ST_RANGE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= key_q;
    rd_data_q <= mem[ptr_d];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= in_cmd_i;
      idx_q <= in_index_i;
      key_q <= in_offset_i;
    end
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    ptr_q <= ptr_d;
    if (cmd_i.exec || cmd_i.scan) begin
      res_blk_q <= res_blk_d;
      res_st_q  <= res_st_d;
    end
    if (cmd_i.out_load) begin
      out_blk_q <= res_blk_q;
      out_st_q  <= res_st_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.exec && is_append && !full) count_q <= count_q + CW'(1);
      if (cmd_i.out_load)   out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign status_o.is_lookup = is_lookup;
  assign status_o.empty     = empty;
  assign status_o.wide      = wide;
  assign status_o.scan_end  = scan_end;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign out_block_o  = out_blk_q;
  assign out_status_o = out_st_q;

endmodule

`default_nettype wire

@@ src/sorted_offset_floor_search_table.sv @@
// sorted offset table with append, modify and floor lookup
//
//   channel  dir  payload                              beat taken when
//   req_i    in   cmd, entry_index, offset_value        req_i.valid & req_i.ready
//   rsp_o    out  block_number, status                  rsp_o.valid & rsp_o.ready
//
// one request at a time: accept, execute, then for lookups binary search steps and an
// upward scan of at most LINEAR_SPAN + 1 entries, each step bound by the single registered
// read port of the offset memory
// a finished beat waits in the response register while the next request is taken
// reset clears the entry count and the response valid; the memory is not cleared
`default_nettype none

module sorted_offset_floor_search_table
  import sofst_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = DEF_MAX_ENTRIES
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  sofst_req_if.sink   req_i,
  sofst_rsp_if.source rsp_o
);

  ctrl_cmd_t  ctrl_cmd;
  dp_status_t dp_status;

  sofst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .status_i   (dp_status),
    .cmd_o      (ctrl_cmd)
  );

  sofst_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (ctrl_cmd),
    .status_o     (dp_status),
    .in_cmd_i     (req_i.cmd),
    .in_index_i   (req_i.entry_index),
    .in_offset_i  (req_i.offset_value),
    .out_valid_o  (rsp_o.valid),
    .out_ready_i  (rsp_o.ready),
    .out_block_o  (rsp_o.block_number),
    .out_status_o (rsp_o.status)
  );

endmodule

`default_nettype wire

@@ tb/tb_sorted_offset_floor_search_table.sv @@
// testbench for the sorted offset table: directed rows, random commands, floor search predictor
`default_nettype none

module tb_sorted_offset_floor_search_table;
  import sofst_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned     MAX_ENTRIES   = DEF_MAX_ENTRIES;
  localparam logic [CMD_W-1:0] CMD_UNKNOWN  = 2'd3;
  localparam int              RANDOM_ITEMS  = 580;
  localparam int              STALL_PERCENT = 36;
  localparam int              WATCHDOG_LIMIT = 4000;
  localparam int              REPORT_LIMIT  = 10;

  typedef struct packed {
    logic [BLOCK_W-1:0]  blk;
    logic [STATUS_W-1:0] st;
  } answer_t;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [INDEX_W-1:0]  index;
    logic [OFFSET_W-1:0] offset;
    logic                typed;
    answer_t             ans;
  } stim_row_t;

  localparam int DIRECTED_COUNT = 24;

  // typed answers where obvious, the rest left to the floor search predictor
  localparam stim_row_t DIRECTED_STEPS [DIRECTED_COUNT] = '{
    '{CMD_LOOKUP,  10'd0,    64'd0,   1'b1, '{10'd0, ST_MISS}},   // empty table
    '{CMD_LOOKUP,  10'd1023, '1,      1'b1, '{10'd0, ST_MISS}},
    '{CMD_MODIFY,  10'd0,    64'd5,   1'b1, '{10'd0, ST_RANGE}},
    '{CMD_UNKNOWN, 10'd0,    64'd0,   1'b1, '{10'd0, ST_RANGE}},
    '{CMD_APPEND,  10'd512,  64'd100, 1'b1, '{10'd0, ST_OK}},
    '{CMD_LOOKUP,  10'd0,    64'd99,  1'b1, '{10'd0, ST_MISS}},   // key below first
    '{CMD_LOOKUP,  10'd0,    64'd100, 1'b1, '{10'd0, ST_OK}},
    '{CMD_LOOKUP,  10'd1023, '1,      1'b1, '{10'd0, ST_OK}},
    '{CMD_APPEND,  10'd0,    64'd200, 1'b1, '{10'd1, ST_OK}},
    '{CMD_APPEND,  10'd0,    64'd300, 1'b1, '{10'd2, ST_OK}},
    '{CMD_APPEND,  10'd0,    64'd400, 1'b1, '{10'd3, ST_OK}},
    '{CMD_APPEND,  10'd0,    64'd500, 1'b1, '{10'd4, ST_OK}},
    '{CMD_LOOKUP,  10'd0,    64'd250, 1'b0, '{10'd0, ST_OK}},
    '{CMD_LOOKUP,  10'd0,    64'd500, 1'b0, '{10'd0, ST_OK}},
    '{CMD_MODIFY,  10'd5,    64'd7,   1'b1, '{10'd0, ST_RANGE}},  // index equal to count
    '{CMD_MODIFY,  10'd1023, '1,      1'b1, '{10'd0, ST_RANGE}},
    '{CMD_MODIFY,  10'd2,    64'd301, 1'b1, '{10'd2, ST_OK}},
    '{CMD_UNKNOWN, 10'd1023, '1,      1'b1, '{10'd0, ST_RANGE}},
    '{CMD_APPEND,  10'd0,    '1,      1'b1, '{10'd5, ST_OK}},
    '{CMD_LOOKUP,  10'd0,    '1,      1'b0, '{10'd0, ST_OK}},
    '{CMD_MODIFY,  10'd1,    64'd0,   1'b1, '{10'd1, ST_OK}},     // table no longer increasing
    '{CMD_LOOKUP,  10'd0,    64'd150, 1'b0, '{10'd0, ST_OK}},
    '{CMD_APPEND,  10'd0,    64'd0,   1'b1, '{10'd6, ST_OK}},
    '{CMD_LOOKUP,  10'd0,    64'd0,   1'b0, '{10'd0, ST_OK}}
  };

  logic clk_i;
  logic rst_ni;

  sofst_req_if req_if ();
  sofst_rsp_if rsp_if ();

  sorted_offset_floor_search_table #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  logic [OFFSET_W-1:0] offset_shadow [MAX_ENTRIES];
  int unsigned         shadow_count;
  logic [OFFSET_W-1:0] growth_edge;
  answer_t             pending_answers [$];
  int                  mismatch_count;
  bit                  calm_stretch;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [OFFSET_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [OFFSET_W-1:0] step_gap();
    return (rand64() >> $urandom_range(14, 63)) + 64'd1;
  endfunction

  // last entry not above the key: binary narrowing, then an upward scan
  function automatic answer_t floor_of(input logic [OFFSET_W-1:0] key);
    int unsigned lo, hi, mid, i;
    answer_t     a;
    a = '{'0, ST_MISS};
    if (shadow_count == 0) return a;
    lo = 0;
    hi = shadow_count - 1;
    while (hi - lo > LINEAR_SPAN) begin
      mid = (lo + hi) / 2;
      if (key <= offset_shadow[mid]) hi = mid;
      else lo = mid;
    end
    for (i = lo; i <= hi; i++) begin
      if (offset_shadow[i] > key) break;
    end
    if (i == 0) return a;
    a.blk = BLOCK_W'(i - 1);
    a.st  = ST_OK;
    return a;
  endfunction

  function automatic answer_t resolve_request(input logic [CMD_W-1:0] c,
                                              input logic [INDEX_W-1:0] ix,
                                              input logic [OFFSET_W-1:0] v);
    answer_t a;
    a = '{'0, ST_OK};
    case (c)
      CMD_LOOKUP: a = floor_of(v);
      CMD_APPEND: begin
        if (shadow_count >= MAX_ENTRIES) begin
          a.st = ST_FULL;
        end else begin
          offset_shadow[shadow_count] = v;
          a.blk = BLOCK_W'(shadow_count);
          shadow_count++;
        end
      end
      CMD_MODIFY: begin
        if (ix >= shadow_count) begin
          a.st = ST_RANGE;
        end else begin
          offset_shadow[ix] = v;
          a.blk = ix;
        end
      end
      default: a.st = ST_RANGE;
    endcase
    return a;
  endfunction

  function automatic logic [OFFSET_W-1:0] pick_key();
    int unsigned         i;
    logic [OFFSET_W-1:0] k;
    if (shadow_count == 0) return rand64();
    i = $urandom_range(0, shadow_count - 1);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: k = offset_shadow[i];
      4:          k = offset_shadow[i] - 64'd1;
      5:          k = offset_shadow[i] + 64'd1;
      6:          k = (offset_shadow[0] == '0) ? '0 : rand64() % offset_shadow[0];
      7:          k = '1;
      8:          k = rand64();
      default:    k = offset_shadow[i] + (rand64() >> $urandom_range(8, 63));
    endcase
    return k;
  endfunction

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) $display("mismatch: %s", what);
  endtask

  task automatic send_request(input logic [CMD_W-1:0] c, input logic [INDEX_W-1:0] ix,
                              input logic [OFFSET_W-1:0] v, input logic typed,
                              input answer_t typed_ans);
    int      gap;
    answer_t ans;
    gap = 0;
    while (!calm_stretch && $urandom_range(0, 99) < STALL_PERCENT) gap++;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.cmd          <= c;
    req_if.entry_index  <= ix;
    req_if.offset_value <= v;
    do @(posedge clk_i); while (!req_if.ready);
    ans = resolve_request(c, ix, v);
    pending_answers.insert(pending_answers.size(), typed ? typed_ans : ans);
  endtask

  task automatic random_request();
    logic [CMD_W-1:0]    c;
    logic [INDEX_W-1:0]  ix;
    logic [OFFSET_W-1:0] v, lo_v, hi_v;
    int unsigned         pick;
    pick = $urandom_range(0, 99);
    ix   = INDEX_W'($urandom);
    v    = rand64();
    if (pick < 30) begin
      c = CMD_APPEND;
      // mostly growing offsets, now and then a spike that breaks the order
      if ($urandom_range(0, 19) != 0) begin
        growth_edge += step_gap();
        v = growth_edge;
      end
    end else if (pick < 70) begin
      c = CMD_LOOKUP;
      v = pick_key();
    end else if (pick < 93 && shadow_count > 0 &&
                 (pick < 85 || shadow_count >= MAX_ENTRIES)) begin
      c    = CMD_MODIFY;
      ix   = INDEX_W'($urandom_range(0, shadow_count - 1));
      lo_v = (ix == 0) ? '0 : offset_shadow[ix - 1];
      hi_v = (ix == shadow_count - 1) ? growth_edge : offset_shadow[ix + 1];
      if ($urandom_range(0, 9) != 0 && hi_v > lo_v + 64'd1)
        v = lo_v + 64'd1 + rand64() % (hi_v - lo_v - 64'd1);
    end else if (pick < 93) begin
      c  = CMD_MODIFY;
      ix = ($urandom_range(0, 3) == 0) ? INDEX_W'(shadow_count)
                                       : INDEX_W'($urandom_range(shadow_count, 1023));
    end else begin
      c = CMD_UNKNOWN;
    end
    send_request(c, ix, v, 1'b0, '0);
  endtask

  task automatic drain_answers();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_answers.size() != 0);
  endtask

  always @(posedge clk_i) begin : rsp_monitor
    answer_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_answers.size() == 0) begin
        flag_mismatch($sformatf("unexpected beat: block %0d status %0d",
                                rsp_if.block_number, rsp_if.status));
      end else begin
        want = pending_answers.pop_front();
        if (rsp_if.block_number !== want.blk)
          flag_mismatch($sformatf("block_number expected %0d got %0d",
                                  want.blk, rsp_if.block_number));
        if (rsp_if.status !== want.st)
          flag_mismatch($sformatf("status expected %0d got %0d", want.st, rsp_if.status));
      end
    end
    rsp_if.ready <= calm_stretch || ($urandom_range(0, 99) >= STALL_PERCENT);
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    int n;
    rst_ni              = 1'b0;
    req_if.valid        = 1'b0;
    req_if.cmd          = CMD_LOOKUP;
    req_if.entry_index  = '0;
    req_if.offset_value = '0;
    shadow_count        = 0;
    mismatch_count      = 0;
    calm_stretch        = 1'b0;
    growth_edge         = rand64() >> 8;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (n = 0; n < DIRECTED_COUNT; n++)
      send_request(DIRECTED_STEPS[n].cmd, DIRECTED_STEPS[n].index, DIRECTED_STEPS[n].offset,
                   DIRECTED_STEPS[n].typed, DIRECTED_STEPS[n].ans);

    // put the directed entries back into increasing order
    for (n = 0; n < int'(shadow_count); n++) begin
      growth_edge += step_gap();
      send_request(CMD_MODIFY, INDEX_W'(n), growth_edge, 1'b0, '0);
    end

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      calm_stretch = (n >= 250 && n < 400);
      random_request();
    end
    calm_stretch = 1'b0;

    drain_answers();

    // past the end of the table, then the widest key
    send_request(CMD_MODIFY, 10'd1023, growth_edge + 64'd1, 1'b0, '0);
    send_request(CMD_LOOKUP, '0, '1, 1'b0, '0);
    for (n = 0; n < 40; n++) random_request();

    drain_answers();
    repeat (32) @(posedge clk_i);

    if (mismatch_count == 0 && pending_answers.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire
